// ===== rtl/rspe_pkg.sv =====
package rspe_pkg;

   // GF(256) field polynomial x^8 + x^4 + x^3 + x^2 + 1, low byte
   localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
   localparam logic [5:0] RESET_ECC_LENGTH = 6'd7;
   localparam logic [7:0] FIRST_ROOT = 8'h01;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic       clear_gen;
      logic       clear_rem;
      logic       derive;
      logic       encode;
      logic       load_out;
      logic       shift_out;
      logic [7:0] factor;
      logic [7:0] root;
   } cell_ctrl_type;

   function automatic logic [7:0] gf_xtime(logic [7:0] a);
      logic [7:0] r;
      r = {a[6:0], 1'b0};
      if (a[7]) begin
         r = r ^ FIELD_POLY_LOW;
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ x;
         end
         x = gf_xtime(x);
      end
      return r;
   endfunction

endpackage

// ===== rtl/rspe_channels.sv =====
interface rspe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_data;

   modport source (output valid, output data_byte, output last_data, input ready);
   modport sink   (input valid, input data_byte, input last_data, output ready);
endinterface

interface rspe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] parity_byte;
   logic       last_parity;

   modport source (output valid, output parity_byte, output last_parity, input ready);
   modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

interface rspe_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] ecc_length;

   modport source (output valid, output ecc_length, input ready);
   modport sink   (input valid, input ecc_length, output ready);
endinterface

// ===== rtl/rspe_cell.sv =====
module rspe_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rspe_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             gen_prev,
   input  logic [7:0]             rem_next,
   input  logic [7:0]             out_next,
   output logic [7:0]             gen_q,
   output logic [7:0]             rem_q,
   output logic [7:0]             out_q
);

   logic [7:0] gen_ff, gen_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] out_ff, out_in;
   logic [7:0] mul_a, mul_b, prod, rem_upd;

   // one shared multiplier: root * left neighbor while deriving, factor * coeff while encoding
   always_comb begin
      mul_a   = ctrl.derive ? ctrl.root : ctrl.factor;
      mul_b   = ctrl.derive ? gen_prev : gen_ff;
      prod    = rspe_pkg::gf_mul(mul_a, mul_b);
      rem_upd = rem_next ^ prod;
   end

   always_comb begin
      gen_in = gen_ff;
      if (ctrl.clear_gen) begin
         gen_in = 8'h00;
      end else if (ctrl.derive) begin
         gen_in = gen_ff ^ prod;
      end

      rem_in = rem_ff;
      if (ctrl.clear_rem) begin
         rem_in = 8'h00;
      end else if (ctrl.encode) begin
         rem_in = rem_upd;
      end

      out_in = out_ff;
      if (ctrl.load_out) begin
         out_in = rem_upd;
      end else if (ctrl.shift_out) begin
         out_in = out_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= 8'h00;
         rem_ff <= 8'h00;
      end else begin
         gen_ff <= gen_in;
         rem_ff <= rem_in;
      end
      out_ff <= out_in;
   end

   assign gen_q = gen_ff;
   assign rem_q = rem_ff;
   assign out_q = out_ff;

endmodule

// ===== rtl/reed_solomon_parity_encoder_top.sv =====
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D,
// generator roots alpha^0 .. alpha^(L-1).
// Channels: req (data_byte, last_data) in, rsp (parity_byte, last_parity) out,
// csr (ecc_length) write port, always ready. All use valid/ready; a beat moves
// on a rising edge with both high.
// Throughput: one data beat per cycle. Parity of a block sits in an output
// shift chain, so the next block's bytes are taken while parity drains; only
// a last-marked beat waits for the chain to empty (or empty this cycle).
// Latency: the first parity beat is offered the cycle after the last data
// beat; L parity beats follow at one per cycle while rsp is ready.
// Generator: after reset and after each csr write the chain derives the
// generator polynomial, one root factor per cycle; req is held off during
// that time. A csr write also clears the remainder.
// ecc_length 0 is taken as 1, values above MAX_PARITY as MAX_PARITY.
// Reset: synchronous; L returns to 7, remainder clears, derivation restarts,
// any pending parity is dropped. A stalled rsp holds its beat unchanged.
module reed_solomon_parity_encoder_top #(
   parameter int MAX_PARITY = 32
) (
   input  logic      clock,
   input  logic      reset,
   rspe_req_if.sink  req_bus,
   rspe_rsp_if.source rsp_bus,
   rspe_csr_if.sink  csr_bus
);

   localparam int LEN_W = $clog2(MAX_PARITY + 1);

   function automatic logic [LEN_W-1:0] clamp_len(logic [5:0] v);
      logic [LEN_W-1:0] r;
      if (v == 6'd0) begin
         r = LEN_W'(1);
      end else if (int'(v) > MAX_PARITY) begin
         r = LEN_W'(MAX_PARITY);
      end else begin
         r = LEN_W'(v);
      end
      return r;
   endfunction

   logic [LEN_W-1:0] len_ff, len_in;     // effective parity length L
   logic [LEN_W-1:0] step_ff, step_in;   // derivation steps done
   logic [7:0]       root_ff, root_in;   // alpha^step
   logic [LEN_W-1:0] cnt_ff, cnt_in;     // parity beats still to send

   rspe_pkg::cell_ctrl_type ctrl;

   logic [7:0] gen_q [MAX_PARITY];
   logic [7:0] rem_q [MAX_PARITY];
   logic [7:0] out_q [MAX_PARITY];

   logic deriving, req_fire, rsp_fire, csr_fire, out_free;

   assign deriving = (step_ff != len_ff);
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;
   assign csr_fire = csr_bus.valid && csr_bus.ready;
   assign req_fire = req_bus.valid && req_bus.ready;

   // output chain free now or after the beat leaving this cycle
   assign out_free = (cnt_ff == '0) || ((cnt_ff == LEN_W'(1)) && rsp_bus.ready);

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !deriving && (!req_bus.last_data || out_free);

   assign rsp_bus.valid       = (cnt_ff != '0);
   assign rsp_bus.parity_byte = out_q[0];
   assign rsp_bus.last_parity = (cnt_ff == LEN_W'(1));

   // broadcast control for the cell row
   always_comb begin
      ctrl.clear_gen = csr_fire;
      ctrl.clear_rem = csr_fire || (req_fire && req_bus.last_data);
      ctrl.derive    = deriving && !csr_fire;
      ctrl.encode    = req_fire;
      ctrl.load_out  = req_fire && req_bus.last_data;
      ctrl.shift_out = rsp_fire;
      ctrl.factor    = req_bus.data_byte ^ rem_q[0];
      ctrl.root      = root_ff;
   end

   always_comb begin
      len_in  = len_ff;
      step_in = step_ff;
      root_in = root_ff;
      if (csr_fire) begin
         len_in  = clamp_len(csr_bus.ecc_length);
         step_in = '0;
         root_in = rspe_pkg::FIRST_ROOT;
      end else if (deriving) begin
         step_in = step_ff + LEN_W'(1);
         root_in = rspe_pkg::gf_xtime(root_ff);
      end

      cnt_in = cnt_ff;
      if (req_fire && req_bus.last_data) begin
         cnt_in = len_ff;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= clamp_len(rspe_pkg::RESET_ECC_LENGTH);
         step_ff <= '0;
         root_ff <= rspe_pkg::FIRST_ROOT;
         cnt_ff  <= '0;
      end else begin
         len_ff  <= len_in;
         step_ff <= step_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_in;
      end
   end

   // row of cells: generator flows right while deriving, remainder and
   // parity flow left toward cell 0
   for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
      logic [7:0] gen_prev, rem_next, out_next;
      if (j == 0) begin : g_head
         assign gen_prev = 8'h01;   // implied monic leading coefficient
      end else begin : g_body
         assign gen_prev = gen_q[j-1];
      end
      if (j == MAX_PARITY - 1) begin : g_tail
         assign rem_next = 8'h00;
         assign out_next = 8'h00;
      end else begin : g_link
         assign rem_next = rem_q[j+1];
         assign out_next = out_q[j+1];
      end

      rspe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .gen_prev (gen_prev),
         .rem_next (rem_next),
         .out_next (out_next),
         .gen_q    (gen_q[j]),
         .rem_q    (rem_q[j]),
         .out_q    (out_q[j])
      );
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PARITY = 32;
   // Longest stretch with no beat on any channel before the run is declared hung.
   // Covers the settle pause plus a full MAX_PARITY generator derivation, many times over.
   localparam int IDLE_LIMIT = 2000;
   // Quiet cycles after the last expected parity beat before a csr write or the end.
   localparam int SETTLE_CYCLES = 40;
   localparam logic [7:0] ALPHA = 8'h02;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_data;
   } msg_beat_type;

   typedef struct packed {
      logic [7:0] parity_byte;
      logic       last_parity;
   } parity_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rspe_req_if req_bus();
   rspe_rsp_if rsp_bus();
   rspe_csr_if csr_bus();

   reed_solomon_parity_encoder_top #(
      .MAX_PARITY(MAX_PARITY)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Encoder shadow: ecc setting, generator taps and the running remainder.
   // ---------------------------------------------------------------------
   logic [5:0] ecc_setting;
   logic [7:0] gen_taps [MAX_PARITY];
   logic [7:0] rem_cells [MAX_PARITY];
   parity_beat_type parity_expected [$];

   msg_beat_type pending_bytes [$];
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned csr_writes = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;

   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   logic burst_mode = 1'b0;   // no gaps on either side while set
   int req_gap = 0;
   int rsp_wait = 0;

   // GF(256) multiply, field poly x^8+x^4+x^3+x^2+1, shift-and-add
   function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
      logic [8:0] shifted;
      logic [7:0] prod;
      shifted = {1'b0, a};
      prod = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) begin
            prod = prod ^ shifted[7:0];
         end
         shifted = shifted << 1;
         if (shifted[8]) begin
            shifted = shifted ^ {1'b1, rspe_pkg::FIELD_POLY_LOW};
         end
      end
      return prod;
   endfunction

   // 0 acts as 1, anything above MAX_PARITY is clamped
   function automatic int unsigned parity_len(logic [5:0] setting);
      if (setting == 6'd0) begin
         return 1;
      end
      if (setting > MAX_PARITY) begin
         return MAX_PARITY;
      end
      return 32'(setting);
   endfunction

   // Expand g(x) = prod (x + alpha^i), i < L; taps hold x^(L-1) down to x^0.
   // Any write also drops the partial remainder.
   function automatic void load_generator(logic [5:0] setting);
      logic [7:0] poly [MAX_PARITY+1];
      logic [7:0] root;
      int unsigned n;
      n = parity_len(setting);
      foreach (poly[k]) begin
         poly[k] = 8'h00;
      end
      poly[0] = 8'h01;
      root = rspe_pkg::FIRST_ROOT;
      for (int unsigned i = 0; i < n; i++) begin
         for (int unsigned j = i + 1; j > 0; j--) begin
            poly[j] = poly[j-1] ^ gf_product(poly[j], root);
         end
         poly[0] = gf_product(poly[0], root);
         root = gf_product(root, ALPHA);
      end
      ecc_setting = setting;
      for (int unsigned j = 0; j < MAX_PARITY; j++) begin
         gen_taps[j] = (j < n) ? poly[n-1-j] : 8'h00;
         rem_cells[j] = 8'h00;
      end
   endfunction

   // One LFSR step; a last-marked byte dumps the L remainder cells as parity.
   function automatic void absorb_byte(logic [7:0] data, logic last);
      int unsigned n;
      logic [7:0] factor;
      parity_beat_type beat;
      n = parity_len(ecc_setting);
      factor = data ^ rem_cells[0];
      for (int unsigned j = 0; j + 1 < n; j++) begin
         rem_cells[j] = rem_cells[j+1];
      end
      rem_cells[n-1] = 8'h00;
      for (int unsigned j = 0; j < n; j++) begin
         rem_cells[j] = rem_cells[j] ^ gf_product(gen_taps[j], factor);
      end
      if (last) begin
         for (int unsigned j = 0; j < n; j++) begin
            beat.parity_byte = rem_cells[j];
            beat.last_parity = (j + 1 == n);
            parity_expected.push_back(beat);
         end
         for (int unsigned j = 0; j < MAX_PARITY; j++) begin
            rem_cells[j] = 8'h00;
         end
      end
   endfunction

   function automatic void report_mismatch(string what, logic [8:0] want, logic [8:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled on the rising edge. Data beats feed the
   // shadow, csr beats reload it, parity beats are checked in order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      parity_beat_type want;
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         rsp_fired <= rsp_bus.valid && rsp_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            absorb_byte(req_bus.data_byte, req_bus.last_data);
            bytes_taken++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            load_generator(csr_bus.ecc_length);
            csr_writes++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (parity_expected.size() == 0) begin
               report_mismatch("unexpected parity beat", 9'h000,
                               {rsp_bus.parity_byte, rsp_bus.last_parity});
            end else begin
               want = parity_expected.pop_front();
               if (rsp_bus.parity_byte !== want.parity_byte) begin
                  report_mismatch("parity_byte", {1'b0, want.parity_byte},
                                  {1'b0, rsp_bus.parity_byte});
               end
               if (rsp_bus.last_parity !== want.last_parity) begin
                  report_mismatch("last_parity", {8'h00, want.last_parity},
                                  {8'h00, rsp_bus.last_parity});
               end
            end
         end
         // watchdog: any beat on any channel counts as progress
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
               $display("end of test: mismatches");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Data driver: falling edge, one beat in flight, random gap after each.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      msg_beat_type next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= 8'h00;
         req_bus.last_data <= 1'b0;
         req_gap <= 0;
      end else if (!req_bus.valid || req_fired) begin
         if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_bytes.size() != 0) begin
            next_beat = pending_bytes.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= next_beat.data_byte;
            req_bus.last_data <= next_beat.last_data;
            req_gap <= burst_mode ? 0 : $urandom_range(0, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Parity sink: after each accepted beat, ready drops for a randomly drawn stall, or not at all.
   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_fired) begin
         stall = burst_mode ? 0 : $urandom_range(0, 3);
         rsp_wait <= stall;
         rsp_bus.ready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_bus.ready <= (rsp_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequencing
   // ---------------------------------------------------------------------
   // Called at a rising edge so queue pushes never race the driver.
   task automatic queue_beat(logic [7:0] data, logic last);
      msg_beat_type beat;
      beat.data_byte = data;
      beat.last_data = last;
      pending_bytes.push_back(beat);
      bytes_queued++;
   endtask

   task automatic queue_block(int count, bit closed);
      logic [7:0] data;
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 7);
         data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
         queue_beat(data, closed && (k == count - 1));
      end
   endtask

   task automatic start_phase();
      @(posedge clock);
      burst_mode = ($urandom_range(0, 3) == 0);
   endtask

   // Hold off the sender until every data beat is in and all parity is out,
   // then let the block go quiet.
   task automatic settle();
      @(negedge clock);
      while (bytes_taken != bytes_queued || parity_expected.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ecc(logic [5:0] setting);
      int unsigned seen;
      seen = csr_writes;
      csr_bus.valid <= 1'b1;
      csr_bus.ecc_length <= setting;
      do begin
         @(negedge clock);
      end while (csr_writes == seen);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int left;
      int len;
      bit partial;
      logic [5:0] setting;

      csr_bus.valid = 1'b0;
      csr_bus.ecc_length = 6'd0;
      load_generator(rspe_pkg::RESET_ECC_LENGTH);

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Reset length (7): single-byte blocks at both extremes, then a mixed block.
      // A leading zero byte into a clear remainder gives a zero feedback factor.
      start_phase();
      queue_beat(8'h00, 1'b1);
      queue_beat(8'hFF, 1'b1);
      queue_beat(8'h01, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h00, 1'b1);
      settle();

      // zero length acts as one parity byte
      write_ecc(6'd0);
      start_phase();
      queue_beat(8'h5A, 1'b0);
      queue_beat(8'hA5, 1'b1);
      settle();

      // all ones: clamps to the longest generator
      write_ecc(6'd63);
      start_phase();
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h00, 1'b0);
      queue_beat(8'h7F, 1'b1);
      settle();

      // just past the maximum
      write_ecc(6'd33);
      start_phase();
      queue_beat(8'h01, 1'b1);
      settle();

      // exact maximum, block left open; next write must discard the partial remainder
      write_ecc(6'd32);
      start_phase();
      queue_beat(8'h12, 1'b0);
      queue_beat(8'h34, 1'b0);
      settle();
      write_ecc(6'd1);
      start_phase();
      queue_beat(8'hC3, 1'b1);
      settle();

      // Random phases: mostly closed blocks of short length, some long ones,
      // some left open before the next write, and a few phases with no write
      // (sender just waits for the parity to drain).
      for (int p = 0; p < 12; p++) begin
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 3))
               0: setting = 6'($urandom_range(0, 63));
               1: setting = 6'($urandom_range(28, 32));
               default: setting = 6'($urandom_range(1, 12));
            endcase
            write_ecc(setting);
         end
         start_phase();
         left = 39;
         while (left > 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            if (len > left) begin
               len = left;
            end
            partial = (len == left) && ($urandom_range(0, 3) == 0);
            queue_block(len, !partial);
            left -= len;
         end
         settle();
      end

      if (mismatch_count == 0 && parity_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
